### rtl/tcc_pkg.sv
package tcc_pkg;

  // Compressed record slots, in emission order
  localparam int SLOT_COUNT = 14;

  localparam int SLOT_PLAYER   = 0;
  localparam int SLOT_TICK     = 1;
  localparam int SLOT_CONSIST  = 2;
  localparam int SLOT_CTRL     = 3;
  localparam int SLOT_FORWARD  = 4;
  localparam int SLOT_SIDE     = 5;
  localparam int SLOT_UPDOWN   = 6;
  localparam int SLOT_ANGLE_LO = 7;
  localparam int SLOT_ANGLE_HI = 8;
  localparam int SLOT_BUTTONS  = 9;
  localparam int SLOT_CONSOLE0 = 10;

  // Control byte layout
  localparam int CTRL_FORWARD     = 0;
  localparam int CTRL_SIDE        = 1;
  localparam int CTRL_UPDOWN      = 2;
  localparam int CTRL_ANGLE       = 3;
  localparam int CTRL_BUTTONS     = 4;
  localparam int CTRL_COUNT_SHIFT = 5;
  localparam int CTRL_COUNT_W     = 3;

  // Console bytes: carried in the record, and the send limit
  localparam int CONSOLE_BYTE_COUNT = 4;
  localparam int CONSOLE_CARRIED    = 4;
  localparam int CONSOLE_LIMIT      = (CONSOLE_BYTE_COUNT > CONSOLE_CARRIED) ?
                                      CONSOLE_CARRIED : CONSOLE_BYTE_COUNT;

  localparam int IN_DATA_W = 104;

  // Classified record: bytes by slot and which slots are sent
  typedef struct packed {
    logic [SLOT_COUNT-1:0]      send;
    logic [SLOT_COUNT-1:0][7:0] bytes;
  } tcc_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } tcc_q_stat_t;

endpackage

### rtl/tcc_front.sv
module tcc_front
  import tcc_pkg::*;
(
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  tcc_q_stat_t          q_stat,
  output logic                 q_push,
  output tcc_entry_t           q_entry
);

  logic [7:0]               player_id;
  logic [7:0]               tick_number;
  logic [7:0]               consistency_low;
  logic signed [7:0]        forward_move;
  logic signed [7:0]        side_move;
  logic signed [7:0]        look_updown;
  logic signed [15:0]       turn_angle;
  logic [7:0]               button_bits;
  logic [31:0]              console_bytes;
  logic [CONSOLE_CARRIED-1:0] cons_en;
  logic [CTRL_COUNT_W-1:0]  cons_cnt;
  logic [7:0]               ctrl;

  assign player_id       = in_tdata[7:0];
  assign tick_number     = in_tdata[15:8];
  assign consistency_low = in_tdata[23:16];
  assign forward_move    = in_tdata[31:24];
  assign side_move       = in_tdata[39:32];
  assign look_updown     = in_tdata[47:40];
  assign turn_angle      = in_tdata[63:48];
  assign button_bits     = in_tdata[71:64];
  assign console_bytes   = in_tdata[103:72];

  // Console run stops at the first zero byte or at the limit
  always_comb begin
    logic run;
    run = 1'b1;
    cons_cnt = '0;
    for (int k = 0; k < CONSOLE_CARRIED; k++) begin
      run = run && (console_bytes[8*k +: 8] != 8'd0) && (k < CONSOLE_LIMIT);
      cons_en[k] = run;
      cons_cnt = cons_cnt + CTRL_COUNT_W'(run);
    end
  end

  always_comb begin
    ctrl = '0;
    ctrl[CTRL_FORWARD] = (forward_move != '0);
    ctrl[CTRL_SIDE]    = (side_move != '0);
    ctrl[CTRL_UPDOWN]  = (look_updown != '0);
    ctrl[CTRL_ANGLE]   = (turn_angle != '0);
    ctrl[CTRL_BUTTONS] = (button_bits != '0);
    ctrl[CTRL_COUNT_SHIFT +: CTRL_COUNT_W] = cons_cnt;
  end

  always_comb begin
    q_entry = '0;
    q_entry.bytes[SLOT_PLAYER]   = player_id;
    q_entry.bytes[SLOT_TICK]     = tick_number;
    q_entry.bytes[SLOT_CONSIST]  = consistency_low;
    q_entry.bytes[SLOT_CTRL]     = ctrl;
    q_entry.bytes[SLOT_FORWARD]  = forward_move;
    q_entry.bytes[SLOT_SIDE]     = side_move;
    q_entry.bytes[SLOT_UPDOWN]   = look_updown;
    q_entry.bytes[SLOT_ANGLE_LO] = turn_angle[7:0];
    q_entry.bytes[SLOT_ANGLE_HI] = turn_angle[15:8];
    q_entry.bytes[SLOT_BUTTONS]  = button_bits;
    q_entry.send[SLOT_PLAYER]    = 1'b1;
    q_entry.send[SLOT_TICK]      = 1'b1;
    q_entry.send[SLOT_CONSIST]   = 1'b1;
    q_entry.send[SLOT_CTRL]      = 1'b1;
    q_entry.send[SLOT_FORWARD]   = ctrl[CTRL_FORWARD];
    q_entry.send[SLOT_SIDE]      = ctrl[CTRL_SIDE];
    q_entry.send[SLOT_UPDOWN]    = ctrl[CTRL_UPDOWN];
    q_entry.send[SLOT_ANGLE_LO]  = ctrl[CTRL_ANGLE];
    q_entry.send[SLOT_ANGLE_HI]  = ctrl[CTRL_ANGLE];
    q_entry.send[SLOT_BUTTONS]   = ctrl[CTRL_BUTTONS];
    for (int k = 0; k < CONSOLE_CARRIED; k++) begin
      q_entry.bytes[SLOT_CONSOLE0 + k] = console_bytes[8*k +: 8];
      q_entry.send[SLOT_CONSOLE0 + k]  = cons_en[k];
    end
  end

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && !q_stat.full;

endmodule

### rtl/tcc_queue.sv
module tcc_queue
  import tcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  tcc_entry_t  push_entry,
  input  logic        pop,
  output tcc_entry_t  head,
  output tcc_q_stat_t stat
);

  tcc_entry_t entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head       = entries_r[rd_ptr_r];
  assign stat.valid = (count_r != 2'd0);
  assign stat.full  = (count_r == 2'd2);

endmodule

### rtl/tcc_back.sv
module tcc_back
  import tcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcc_entry_t            head,
  input  tcc_q_stat_t           q_stat,
  output logic                  pop,
  output logic [SLOT_COUNT-1:0] pending,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast
);

  logic [SLOT_COUNT-1:0]      pend_r, pend_nxt;
  logic [SLOT_COUNT-1:0][7:0] bytes_r;
  logic                       valid_r, valid_nxt;
  logic [7:0]                 data_r, data_nxt;
  logic                       last_r, last_nxt;
  logic                       advance;
  logic [SLOT_COUNT-1:0]      sel;
  logic [SLOT_COUNT-1:0]      rest;
  logic [7:0]                 sel_byte;

  // Lowest pending slot goes next
  assign sel  = pend_r & (~pend_r + SLOT_COUNT'(1));
  assign rest = pend_r & ~sel;

  always_comb begin
    sel_byte = '0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      sel_byte = sel_byte | (bytes_r[s] & {8{sel[s]}});
    end
  end

  assign advance = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    pend_nxt  = pend_r;
    if (advance) begin
      valid_nxt = (pend_r != '0);
      data_nxt  = sel_byte;
      last_nxt  = (rest == '0);
      pend_nxt  = rest;
    end
    // refill as soon as the current record has handed out its last byte
    pop = (pend_nxt == '0) && q_stat.valid;
    if (pop) begin
      pend_nxt = head.send;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
    if (pop) begin
      bytes_r <= head.bytes;
    end
  end

  assign pending    = pend_r;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

### rtl/tic_command_compressor.sv
// Channel  | Direction | Beat carries
// ---------+-----------+---------------------------------------------------------
// in_      | input     | one command record (tdata, 104 bits)
// out_     | output    | one byte of the compressed record, tlast on final byte
//
// Each record yields 4 to 14 output beats, one per cycle while out_tready is high; the
// byte-wide output register sets the rate. Records follow each other with no gap when
// queued; the first byte goes out through the queue, pending-slot and output registers.
// A two-record queue sits between the classifier and the byte sequencer.
// Reset (rst_n low, synchronous) empties the queue and drops any pending byte.
// out_tready low holds the output beat; the queue keeps accepting until full.
module tic_command_compressor
  import tcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // player_id[7:0], tick_number[15:8], consistency_low[23:16], forward_move[31:24],
  // side_move[39:32], look_updown[47:40], turn_angle[63:48], button_bits[71:64],
  // console_bytes[103:72]
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // out_byte[7:0]
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  tcc_q_stat_t           q_stat;
  tcc_entry_t            q_entry;
  tcc_entry_t            q_head;
  logic                  q_push;
  logic                  q_pop;
  logic [SLOT_COUNT-1:0] pending;

  tcc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  tcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  tcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .pending    (pending),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // queue only fills on an accepted beat
  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(q_stat.full) |-> $past(in_tvalid))
    else $error("queue filled without input beat");

  // a stalled sequencer keeps its pending slots
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && (pending != '0)) |=> $stable(pending))
    else $error("pending slots changed under stall");

  // bytes of one record flow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("gap inside a record");
`endif

endmodule
